[rtl/ssfs_pkg.sv]
// Shared codes, register indexes, reset values and status type for the
// serial source failover selector. No dependencies.
package ssfs_pkg;

  // request opcodes
  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_RX     = 2'd1;
  localparam logic [1:0] OP_DONE   = 2'd2;
  localparam logic [1:0] OP_SAMPLE = 2'd3;

  // selection modes
  localparam logic [1:0] MODE_AUTO = 2'd0;
  localparam logic [1:0] MODE_ONE  = 2'd1;
  localparam logic [1:0] MODE_TWO  = 2'd2;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_ONE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_LOW  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_AUTO_HIGH = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FORCE_TWO = 3'd4;

  localparam logic [15:0] TIMEOUT_RST   = 16'd100;
  localparam logic [11:0] FORCE_ONE_RST = 12'd1000;
  localparam logic [11:0] AUTO_LOW_RST  = 12'd1500;
  localparam logic [11:0] AUTO_HIGH_RST = 12'd2600;
  localparam logic [11:0] FORCE_TWO_RST = 12'd3100;

  // result fields other than the sent byte
  typedef struct packed {
    logic       send_valid;
    logic       active_source;
    logic [1:0] select_mode;
    logic       byte_dropped;
    logic       first_alive;
    logic       second_alive;
    logic       sending;
  } status_t;

endpackage

[rtl/ssfs_if.sv]
// Request and result channel interfaces (valid/ready) for the serial
// source failover selector. No dependencies.
interface ssfs_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  opcode;
  logic        source_id;
  logic [7:0]  data_byte;
  logic [11:0] switch_sample;

  modport source (output valid, opcode, source_id, data_byte, switch_sample,
                  input ready);
  modport sink   (input valid, opcode, source_id, data_byte, switch_sample,
                  output ready);
endinterface

interface ssfs_out_if;
  logic       valid;
  logic       ready;
  logic       send_valid;
  logic [7:0] send_byte;
  logic       active_source;
  logic [1:0] select_mode;
  logic       byte_dropped;
  logic       first_alive;
  logic       second_alive;
  logic       sending;

  modport source (output valid, send_valid, send_byte, active_source, select_mode,
                  byte_dropped, first_alive, second_alive, sending,
                  input ready);
  modport sink   (input valid, send_valid, send_byte, active_source, select_mode,
                  byte_dropped, first_alive, second_alive, sending,
                  output ready);
endinterface

[rtl/serial_source_failover_selector.sv]
// Serial source failover selector: top level. Uses ssfs_pkg and ssfs_if.
// A request is taken through the state update and ring memory read, then the
// output register, before its result is presented.
// Throughput: one request per cycle unless out_ch back-pressures; the ring
// memory's single read and write ports serve one pop or one push per request.
// Reset (synchronous, rst_n low): mode auto, source one, ring empty,
// transmitter idle, clock and stamps zero, registers at defaults.
module serial_source_failover_selector #(
  parameter int RING_DEPTH = 256
) (
  input  logic                              clk,
  input  logic                              rst_n,
  ssfs_in_if.sink                           in_ch,
  ssfs_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [ssfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssfs_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  localparam int AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);

  // configuration
  logic [15:0] timeout_r;
  logic [11:0] force_one_r, auto_low_r, auto_high_r, force_two_r;

  // control state
  logic [31:0]   now_r, now_nxt;
  logic [31:0]   heard_r [2];
  logic [31:0]   heard_nxt [2];
  logic [1:0]    mode_r, mode_nxt;
  logic          src_r, src_nxt;
  logic [AW-1:0] wr_idx_r, wr_idx_nxt, rd_idx_r, rd_idx_nxt;
  logic          busy_r, busy_nxt;

  // ring memory
  logic [7:0] ring_mem [RING_DEPTH];
  logic [7:0] rdata_r;

  // pipeline and output registers
  logic                p_valid_r, p_use_mem_r;
  logic [7:0]          p_byte_r;
  ssfs_pkg::status_t   p_stat_r, stat;
  logic                out_valid_r;
  logic [7:0]          out_byte_r;
  ssfs_pkg::status_t   out_stat_r;

  logic          o_load, in_ready, in_fire;
  logic          push, pop_mem, send_now, dropped;
  logic [AW-1:0] wr_inc, rd_inc;
  logic          alive0, alive1;

  assign o_load   = p_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !p_valid_r || o_load;
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  assign wr_inc = (wr_idx_r == LAST_IDX) ? '0 : wr_idx_r + 1'b1;
  assign rd_inc = (rd_idx_r == LAST_IDX) ? '0 : rd_idx_r + 1'b1;

  always_comb begin
    now_nxt      = now_r;
    heard_nxt[0] = heard_r[0];
    heard_nxt[1] = heard_r[1];
    mode_nxt     = mode_r;
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    busy_nxt     = busy_r;
    push         = 1'b0;
    pop_mem      = 1'b0;
    send_now     = 1'b0;
    dropped      = 1'b0;

    unique case (in_ch.opcode)
      ssfs_pkg::OP_TICK: begin
        now_nxt = now_r + 32'd1;
      end
      ssfs_pkg::OP_RX: begin
        heard_nxt[in_ch.source_id] = now_r;
        if (in_ch.source_id == src_r) begin
          if (wr_inc == rd_idx_r) begin
            dropped = 1'b1;
          end else begin
            push       = 1'b1;
            wr_idx_nxt = wr_inc;
            // idle transmitter means an empty ring: send the new byte directly
            if (!busy_r) begin
              busy_nxt   = 1'b1;
              send_now   = 1'b1;
              rd_idx_nxt = rd_inc;
            end
          end
        end
      end
      ssfs_pkg::OP_DONE: begin
        if (rd_idx_r == wr_idx_r) begin
          busy_nxt = 1'b0;
        end else begin
          pop_mem    = 1'b1;
          rd_idx_nxt = rd_inc;
        end
      end
      ssfs_pkg::OP_SAMPLE: begin
        priority if (in_ch.switch_sample <= force_one_r) begin
          mode_nxt = ssfs_pkg::MODE_ONE;
        end else if (in_ch.switch_sample >= auto_low_r &&
                     in_ch.switch_sample <= auto_high_r) begin
          mode_nxt = ssfs_pkg::MODE_AUTO;
        end else if (in_ch.switch_sample >= force_two_r) begin
          mode_nxt = ssfs_pkg::MODE_TWO;
        end else begin
          mode_nxt = mode_r;
        end
      end
      default: begin
        now_nxt = now_r;
      end
    endcase

    alive0 = (heard_nxt[0] != 32'd0) &&
             ((now_nxt - heard_nxt[0]) < {16'd0, timeout_r});
    alive1 = (heard_nxt[1] != 32'd0) &&
             ((now_nxt - heard_nxt[1]) < {16'd0, timeout_r});

    priority if (mode_nxt == ssfs_pkg::MODE_ONE) begin
      src_nxt = 1'b0;
    end else if (mode_nxt == ssfs_pkg::MODE_TWO) begin
      src_nxt = 1'b1;
    end else if (alive0) begin
      src_nxt = 1'b0;
    end else if (alive1) begin
      src_nxt = 1'b1;
    end else begin
      src_nxt = src_r;
    end

    stat.send_valid    = send_now || pop_mem;
    stat.active_source = src_nxt;
    stat.select_mode   = mode_nxt;
    stat.byte_dropped  = dropped;
    stat.first_alive   = alive0;
    stat.second_alive  = alive1;
    stat.sending       = busy_nxt;
  end

  // configuration writes; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r   <= ssfs_pkg::TIMEOUT_RST;
      force_one_r <= ssfs_pkg::FORCE_ONE_RST;
      auto_low_r  <= ssfs_pkg::AUTO_LOW_RST;
      auto_high_r <= ssfs_pkg::AUTO_HIGH_RST;
      force_two_r <= ssfs_pkg::FORCE_TWO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssfs_pkg::REG_TIMEOUT:   timeout_r   <= cfg_wdata;
        ssfs_pkg::REG_FORCE_ONE: force_one_r <= cfg_wdata[11:0];
        ssfs_pkg::REG_AUTO_LOW:  auto_low_r  <= cfg_wdata[11:0];
        ssfs_pkg::REG_AUTO_HIGH: auto_high_r <= cfg_wdata[11:0];
        ssfs_pkg::REG_FORCE_TWO: force_two_r <= cfg_wdata[11:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r      <= '0;
      heard_r[0] <= '0;
      heard_r[1] <= '0;
      mode_r     <= ssfs_pkg::MODE_AUTO;
      src_r      <= 1'b0;
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      busy_r     <= 1'b0;
    end else if (in_fire) begin
      now_r      <= now_nxt;
      heard_r[0] <= heard_nxt[0];
      heard_r[1] <= heard_nxt[1];
      mode_r     <= mode_nxt;
      src_r      <= src_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      busy_r     <= busy_nxt;
    end
  end

  // ring memory: at most one write or one registered read per request
  always_ff @(posedge clk) begin
    if (in_fire && push) begin
      ring_mem[wr_idx_r] <= in_ch.data_byte;
    end
    if (in_fire && pop_mem) begin
      rdata_r <= ring_mem[rd_idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
    end else if (in_fire) begin
      p_valid_r <= 1'b1;
    end else if (o_load) begin
      p_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_stat_r    <= stat;
      p_use_mem_r <= pop_mem;
      p_byte_r    <= send_now ? in_ch.data_byte : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (o_load) begin
      out_stat_r <= p_stat_r;
      out_byte_r <= p_use_mem_r ? rdata_r : p_byte_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.send_valid    = out_stat_r.send_valid;
  assign out_ch.send_byte     = out_byte_r;
  assign out_ch.active_source = out_stat_r.active_source;
  assign out_ch.select_mode   = out_stat_r.select_mode;
  assign out_ch.byte_dropped  = out_stat_r.byte_dropped;
  assign out_ch.first_alive   = out_stat_r.first_alive;
  assign out_ch.second_alive  = out_stat_r.second_alive;
  assign out_ch.sending       = out_stat_r.sending;

endmodule
